### sv/cbts_pkg.sv
// Shared types, codes and helpers for the camera bus transaction sequencer.
// No dependencies; imported by every module of the block.
package cbts_pkg;

    localparam int unsigned OP_W       = 3;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned LEN_W      = 8;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_DATA_W   = 48;
    localparam int unsigned M_DATA_W   = 16;

    // event codes
    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_REQ   = 3'd1;
    localparam logic [OP_W-1:0] OP_MATCH = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP  = 3'd3;
    localparam logic [OP_W-1:0] OP_POLL  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE           = 3'd0,
        PH_AWAIT_CMD_READ = 3'd1,
        PH_SENDING_CMD    = 3'd2,
        PH_AWAIT_REPLY    = 3'd3,
        PH_RECEIVING      = 3'd4,
        PH_AWAIT_RSP_READ = 3'd5,
        PH_SENDING_RSP    = 3'd6
    } t_phase;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] now_us;
        logic              cam_reads;
        logic [LEN_W-1:0]  cmd_len;
        logic              rx_has_response;
        logic              follow_on_cmd;
    } t_item;

    typedef struct packed {
        logic              request_refused;
        logic              txn_failed;
        logic              start_receive;
        logic [LEN_W-1:0]  send_len;
        logic              start_send;
        logic              intr_drive;
        t_phase            phase;
    } t_result;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

### sv/cbts_core.sv
// Sequencer state, configuration registers and the single-pass next-state logic.
// Depends on cbts_pkg.
module cbts_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [cbts_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [cbts_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                         i_fire,
    input  cbts_pkg::t_item              i_item,
    output cbts_pkg::t_result            o_result
);
    import cbts_pkg::*;

    logic [15:0]       r_settle, r_ignore, r_timeout;
    logic [7:0]        r_retry_len;

    t_phase            r_phase, n_phase;
    logic              r_active, n_active;
    logic              r_is_tx, n_is_tx;
    logic              r_line, n_line;
    logic              r_waiting, n_waiting;
    logic              r_pulsing, n_pulsing;
    logic [CNT_W-1:0]  r_icnt, n_icnt;
    logic [CNT_W-1:0]  r_xcnt, n_xcnt;
    logic [TIME_W-1:0] r_last_stop, n_last_stop;
    logic [LEN_W-1:0]  r_pending, n_pending;

    logic              settled;
    logic [TIME_W-1:0] elapsed;
    logic              start_send, start_rx, failed, refused, do_begin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle    <= 16'd500;
            r_ignore    <= 16'd666;
            r_retry_len <= 8'd0;
            r_timeout   <= 16'd100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SETTLE:  r_settle    <= i_cfg_wdata;
                CFG_IGNORE:  r_ignore    <= i_cfg_wdata;
                CFG_RETRY:   r_retry_len <= i_cfg_wdata[7:0];
                CFG_TIMEOUT: r_timeout   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_active    = r_active;
        n_is_tx     = r_is_tx;
        n_line      = r_line;
        n_waiting   = r_waiting;
        n_pulsing   = r_pulsing;
        n_icnt      = r_icnt;
        n_xcnt      = r_xcnt;
        n_last_stop = r_last_stop;
        n_pending   = r_pending;
        start_send  = 1'b0;
        start_rx    = 1'b0;
        failed      = 1'b0;
        refused     = 1'b0;
        do_begin    = 1'b0;

        // a stop moves the settle reference before any assertion it causes
        n_last_stop = (i_item.op == OP_STOP) ? i_item.now_us : r_last_stop;
        elapsed     = i_item.now_us - n_last_stop;
        settled     = elapsed > {16'd0, r_settle};

        unique case (i_item.op)
            OP_TICK: begin
                if (r_pulsing) begin
                    n_icnt = sat_inc(r_icnt);
                    if (n_icnt >= {8'd0, r_retry_len}) begin
                        if (settled) n_line = 1'b1;
                        else         n_waiting = 1'b1;
                        n_pulsing = 1'b0;
                        n_icnt    = '0;
                    end
                end else if (r_line) begin
                    n_icnt = sat_inc(r_icnt);
                    if (n_icnt >= r_ignore) begin
                        n_line    = 1'b0;
                        n_pulsing = 1'b1;
                        n_icnt    = '0;
                    end
                end else begin
                    n_icnt = '0;
                end
                if (r_active) begin
                    n_xcnt = sat_inc(r_xcnt);
                    if (r_xcnt > r_timeout) begin
                        n_active = 1'b0;
                        n_xcnt   = '0;
                        n_line   = 1'b0;
                        failed   = 1'b1;
                        n_phase  = PH_IDLE;
                    end
                end
            end
            OP_REQ: begin
                if (r_phase != PH_IDLE) refused  = 1'b1;
                else                    do_begin = 1'b1;
            end
            OP_MATCH: begin
                n_line   = 1'b0;
                n_xcnt   = '0;
                n_active = 1'b1;
                n_is_tx  = i_item.cam_reads;
                if (i_item.cam_reads) begin
                    if (r_phase == PH_AWAIT_CMD_READ) begin
                        start_send = 1'b1;
                        n_phase    = PH_SENDING_CMD;
                    end else if (r_phase == PH_AWAIT_RSP_READ) begin
                        start_send = 1'b1;
                        n_phase    = PH_SENDING_RSP;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end else begin
                    // camera preempts our pending command by writing first
                    failed = (r_phase == PH_AWAIT_CMD_READ);
                    if (r_phase == PH_AWAIT_CMD_READ || r_phase == PH_IDLE ||
                        r_phase == PH_AWAIT_REPLY) begin
                        start_rx = 1'b1;
                        n_phase  = PH_RECEIVING;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            OP_STOP: begin
                if (r_active) begin
                    n_active = 1'b0;
                    n_xcnt   = '0;
                    if (r_is_tx) begin
                        if (r_phase == PH_SENDING_CMD) begin
                            n_phase = PH_AWAIT_REPLY;
                        end else if (r_phase == PH_SENDING_RSP) begin
                            n_phase  = PH_IDLE;
                            do_begin = i_item.follow_on_cmd;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end else if (r_phase == PH_RECEIVING) begin
                        if (i_item.rx_has_response) begin
                            n_pending = i_item.cmd_len;
                            if (settled) n_line = 1'b1;
                            else         n_waiting = 1'b1;
                            n_phase = PH_AWAIT_RSP_READ;
                        end else begin
                            n_phase  = PH_IDLE;
                            do_begin = i_item.follow_on_cmd;
                        end
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            OP_POLL: begin
                if (r_waiting && settled) begin
                    n_line    = 1'b1;
                    n_waiting = 1'b0;
                end
            end
            default: ;
        endcase

        // start a command exchange: load length, raise or defer the interrupt
        if (do_begin) begin
            n_pending = i_item.cmd_len;
            if (settled) n_line = 1'b1;
            else         n_waiting = 1'b1;
            n_xcnt  = '0;
            n_phase = PH_AWAIT_CMD_READ;
        end

        o_result.phase           = n_phase;
        o_result.intr_drive      = n_line;
        o_result.start_send      = start_send;
        o_result.send_len        = start_send ? n_pending : '0;
        o_result.start_receive   = start_rx;
        o_result.txn_failed      = failed;
        o_result.request_refused = refused;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_active    <= 1'b0;
            r_is_tx     <= 1'b0;
            r_line      <= 1'b0;
            r_waiting   <= 1'b0;
            r_pulsing   <= 1'b0;
            r_icnt      <= '0;
            r_xcnt      <= '0;
            r_last_stop <= '0;
            r_pending   <= '0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_active    <= n_active;
            r_is_tx     <= n_is_tx;
            r_line      <= n_line;
            r_waiting   <= n_waiting;
            r_pulsing   <= n_pulsing;
            r_icnt      <= n_icnt;
            r_xcnt      <= n_xcnt;
            r_last_stop <= n_last_stop;
            r_pending   <= n_pending;
        end
    end

endmodule

### sv/cbts_out.sv
// Result register of the sequencer: holds one finished word until the sink takes it.
// Depends on cbts_pkg.
module cbts_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  cbts_pkg::t_result    i_result,
    input  logic                 i_take,
    output logic                 o_valid,
    output cbts_pkg::t_result    o_result
);
    import cbts_pkg::*;

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### sv/camera_bus_transaction_sequencer.sv
// Top level of the camera bus transaction sequencer: input register, handshake control.
// Depends on cbts_pkg, cbts_core and cbts_out.
//
// Usage:
//   Slave stream: one event word per handshake. tuser carries the event code
//   (tick, command request, address match, stop, fast poll); tdata carries the
//   time stamp and the handler flags. Master stream: exactly one result word
//   per event, in order: phase, interrupt drive and the one-shot pulses.
//   Config port: write i_cfg_we with an index (0 settle time, 1 ignore ticks,
//   2 retry pulse ticks, 3 transfer timeout) and data; only while idle.
// Timing:
//   Event word lands in an input register; the sequencer state and the result
//   register update from that register when the result register is free or
//   being drained, and master tvalid rises as the result register loads. One
//   event per cycle is sustained while the sink holds tready high; the next
//   word is taken while the previous result still waits.
// Reset (synchronous, active low): phase idle, interrupt released, counters
//   cleared, config registers at their defaults, both streams empty.
// Stall: when the master side holds tready low the result register holds,
//   the input register fills, then slave tready drops until the sink drains.
module camera_bus_transaction_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write port
    input  logic                             i_cfg_we,
    input  logic [cbts_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [cbts_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // slave stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] now_us, [32] cam_reads, [40:33] cmd_len,
    // [41] rx_has_response, [42] follow_on_cmd, [47:43] zero
    input  logic [cbts_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // [2:0] op
    input  logic [cbts_pkg::OP_W-1:0]        s_axis_tuser,
    // master stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] phase, [3] intr_drive, [4] start_send, [12:5] send_len,
    // [13] start_receive, [14] txn_failed, [15] request_refused
    output logic [cbts_pkg::M_DATA_W-1:0]    m_axis_tdata
);
    import cbts_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    advance;
    logic    in_fire;
    logic    out_valid;
    t_result core_result;
    t_result out_result;

    // process the held event when the result register is free or being drained
    assign advance       = r_in_valid && (!out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // capture the event fields
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.op              <= s_axis_tuser;
            r_item.now_us          <= s_axis_tdata[31:0];
            r_item.cam_reads       <= s_axis_tdata[32];
            r_item.cmd_len         <= s_axis_tdata[40:33];
            r_item.rx_has_response <= s_axis_tdata[41];
            r_item.follow_on_cmd   <= s_axis_tdata[42];
        end
    end

    cbts_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (advance),
        .i_item      (r_item),
        .o_result    (core_result)
    );

    cbts_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (core_result),
        .i_take   (m_axis_tready),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {out_result.request_refused,
                            out_result.txn_failed,
                            out_result.start_receive,
                            out_result.send_len,
                            out_result.start_send,
                            out_result.intr_drive,
                            out_result.phase};

endmodule

### dv/camera_bus_transaction_sequencer_test.sv
// Self-checking bench for the camera bus transaction sequencer: directed rows, then
// random exchanges under several register settings, every result word checked.
// Depends on cbts_pkg and the camera_bus_transaction_sequencer RTL.
module camera_bus_transaction_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cbts_pkg::*;

    // event codes the block must ignore
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    localparam int unsigned RANDOM_PHASES   = 10;
    localparam int unsigned ITEMS_PER_PHASE = 170;
    localparam int unsigned MAX_REPORTS     = 10;
    // time to pass the input and result registers, plus margin
    localparam int unsigned FLUSH_CYCLES    = 6;

    typedef struct packed {
        t_item   ev;
        logic    typed;
        t_result want;
    } t_row;

    // ---------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ---------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [OP_W-1:0]       s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;

    camera_bus_transaction_sequencer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Sequencer prediction: own copy of the registers and of the state
    // ---------------------------------------------------------------------
    logic [15:0]       settle_us, ignore_ticks, timeout_ticks;
    logic [7:0]        pulse_ticks;
    t_phase            seq_phase;
    logic              xfer_on, xfer_tx, line_up, line_pending, pulsing;
    logic [CNT_W-1:0]  line_ticks, xfer_ticks;
    logic [TIME_W-1:0] stop_stamp;
    logic [LEN_W-1:0]  queued_len;

    t_result expected_words[$];

    // bookkeeping
    int unsigned events_sent, directed_count, settings_used;
    int unsigned words_seen, mismatches, sends_seen, receives_seen;
    int unsigned failures_seen, refusals_seen, cycle_count;
    logic        calm = 1'b0;   // no idling on either side while set
    int unsigned sink_hold = 0;
    logic [TIME_W-1:0] clock_us;

    function automatic logic [CNT_W-1:0] bump16(input logic [CNT_W-1:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // assert the line now if the bus has settled, else remember the request
    task automatic raise_intr(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        elapsed = now - stop_stamp;
        if (elapsed > settle_us)
            line_up = 1'b1;
        else
            line_pending = 1'b1;
    endtask

    task automatic open_command(input logic [LEN_W-1:0] len, input logic [TIME_W-1:0] now,
                                output logic ok);
        ok = (seq_phase == PH_IDLE);
        if (ok) begin
            queued_len = len;
            raise_intr(now);
            xfer_ticks = '0;
            seq_phase  = PH_AWAIT_CMD_READ;
        end
    endtask

    task automatic close_exchange(input t_item ev);
        logic ok;
        seq_phase = PH_IDLE;
        if (ev.follow_on_cmd)
            open_command(ev.cmd_len, ev.now_us, ok);
    endtask

    task automatic advance_sequencer(input t_item ev, output t_result res);
        logic [CNT_W-1:0]  prior;
        logic [TIME_W-1:0] elapsed;
        logic              ok;
        res = '0;
        case (ev.op)
            OP_TICK: begin
                if (pulsing) begin
                    line_ticks = bump16(line_ticks);
                    if (line_ticks >= pulse_ticks) begin
                        raise_intr(ev.now_us);
                        pulsing    = 1'b0;
                        line_ticks = '0;
                    end
                end else if (line_up) begin
                    line_ticks = bump16(line_ticks);
                    if (line_ticks >= ignore_ticks) begin
                        line_up    = 1'b0;
                        pulsing    = 1'b1;
                        line_ticks = '0;
                    end
                end else begin
                    line_ticks = '0;
                end
                if (xfer_on) begin
                    prior      = xfer_ticks;
                    xfer_ticks = bump16(xfer_ticks);
                    if (prior > timeout_ticks) begin
                        // abandon the transfer
                        xfer_on        = 1'b0;
                        xfer_ticks     = '0;
                        line_up        = 1'b0;
                        res.txn_failed = 1'b1;
                        seq_phase      = PH_IDLE;
                    end
                end
            end
            OP_REQ: begin
                open_command(ev.cmd_len, ev.now_us, ok);
                res.request_refused = !ok;
            end
            OP_MATCH: begin
                line_up    = 1'b0;
                xfer_ticks = '0;
                xfer_on    = 1'b1;
                xfer_tx    = ev.cam_reads;
                if (ev.cam_reads) begin
                    if (seq_phase == PH_AWAIT_CMD_READ) begin
                        res.start_send = 1'b1;
                        seq_phase      = PH_SENDING_CMD;
                    end else if (seq_phase == PH_AWAIT_RSP_READ) begin
                        res.start_send = 1'b1;
                        seq_phase      = PH_SENDING_RSP;
                    end else begin
                        seq_phase = PH_IDLE;
                    end
                end else begin
                    // a camera write while our command waits preempts it
                    if (seq_phase == PH_AWAIT_CMD_READ)
                        res.txn_failed = 1'b1;
                    if (seq_phase == PH_AWAIT_CMD_READ || seq_phase == PH_IDLE ||
                        seq_phase == PH_AWAIT_REPLY) begin
                        res.start_receive = 1'b1;
                        seq_phase         = PH_RECEIVING;
                    end else begin
                        seq_phase = PH_IDLE;
                    end
                end
            end
            OP_STOP: begin
                stop_stamp = ev.now_us;
                if (xfer_on) begin
                    xfer_on    = 1'b0;
                    xfer_ticks = '0;
                    if (xfer_tx) begin
                        if (seq_phase == PH_SENDING_CMD)
                            seq_phase = PH_AWAIT_REPLY;
                        else if (seq_phase == PH_SENDING_RSP)
                            close_exchange(ev);
                        else
                            seq_phase = PH_IDLE;
                    end else if (seq_phase == PH_RECEIVING) begin
                        if (ev.rx_has_response) begin
                            queued_len = ev.cmd_len;
                            raise_intr(ev.now_us);
                            seq_phase = PH_AWAIT_RSP_READ;
                        end else begin
                            close_exchange(ev);
                        end
                    end else begin
                        seq_phase = PH_IDLE;
                    end
                end
            end
            OP_POLL: begin
                elapsed = ev.now_us - stop_stamp;
                if (line_pending && elapsed > settle_us) begin
                    line_up      = 1'b1;
                    line_pending = 1'b0;
                end
            end
            default: ;
        endcase
        res.phase      = seq_phase;
        res.intr_drive = line_up;
        if (res.start_send)
            res.send_len = queued_len;
    endtask

    // ---------------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 15);
        if (r < 9)
            return 0;
        if (r < 15)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // present one event word, wait for the handshake, then predict its result
    task automatic push_event(input t_item ev, input logic typed, input t_result want);
        int unsigned gap;
        t_result     calc;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, ev.follow_on_cmd, ev.rx_has_response, ev.cmd_len,
                          ev.cam_reads, ev.now_us};
        s_axis_tuser  <= ev.op;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        advance_sequencer(ev, calc);
        expected_words.push_back(typed ? want : calc);
        events_sent++;
    endtask

    // hold the sender until every expected word is out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_SETTLE:  settle_us     = val;
            CFG_IGNORE:  ignore_ticks  = val;
            CFG_RETRY:   pulse_ticks   = val[7:0];
            CFG_TIMEOUT: timeout_ticks = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [15:0] settle, input logic [15:0] ignore,
                                 input logic [7:0] pulse, input logic [15:0] limit);
        drain_results();
        repeat (FLUSH_CYCLES) @(posedge i_clk);
        write_reg(CFG_SETTLE, settle);
        write_reg(CFG_IGNORE, ignore);
        write_reg(CFG_RETRY, {8'd0, pulse});
        write_reg(CFG_TIMEOUT, limit);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // ---------------------------------------------------------------------
    // Random exchange generation
    // ---------------------------------------------------------------------
    function automatic logic rbit();
        return $urandom_range(0, 1);
    endfunction

    function automatic logic [LEN_W-1:0] rlen();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return $urandom_range(0, 255);
    endfunction

    task automatic advance_clock();
        if ($urandom_range(0, 24) == 0)
            clock_us = $urandom;
        else
            clock_us += $urandom_range(0, (settle_us >> 1) + 20);
    endtask

    // intended word most of the time, now and then a stray word or nothing
    task automatic emit(input logic [OP_W-1:0] op, input logic as_tx,
                        input logic [LEN_W-1:0] len, input logic rsp, input logic follow);
        t_item       ev;
        int unsigned pick;
        pick = $urandom_range(0, 29);
        if (pick == 0)
            return;
        ev.op              = op;
        ev.now_us          = clock_us;
        ev.cam_reads       = as_tx;
        ev.cmd_len         = len;
        ev.rx_has_response = rsp;
        ev.follow_on_cmd   = follow;
        if (pick == 1) begin
            ev.op              = $urandom_range(0, 7);
            ev.now_us          = $urandom_range(0, 1) ? clock_us : $urandom;
            ev.cam_reads       = rbit();
            ev.rx_has_response = rbit();
            ev.follow_on_cmd   = rbit();
        end
        push_event(ev, 1'b0, '0);
    endtask

    // housekeeping between bus transfers: ticks and fast polls
    task automatic idle_events();
        int unsigned n;
        n = $urandom_range(0, 5);
        repeat (n) begin
            advance_clock();
            emit(($urandom_range(0, 2) == 0) ? OP_TICK : OP_POLL,
                 rbit(), rlen(), rbit(), rbit());
        end
    endtask

    // ticks during a transfer, sometimes enough to run into the timeout
    task automatic transfer_ticks();
        int unsigned n;
        if ($urandom_range(0, 3) == 0)
            n = timeout_ticks + $urandom_range(0, 3);
        else
            n = $urandom_range(0, timeout_ticks);
        if (n > 40)
            n = $urandom_range(0, 40);
        repeat (n) emit(OP_TICK, rbit(), rlen(), rbit(), rbit());
    endtask

    task automatic run_exchange();
        if ($urandom_range(0, 3) != 0) begin
            // we request, the camera reads our command
            emit(OP_REQ, rbit(), rlen(), rbit(), rbit());
            idle_events();
            emit(OP_MATCH, 1'b1, rlen(), rbit(), rbit());
            transfer_ticks();
            advance_clock();
            emit(OP_STOP, rbit(), rlen(), rbit(), rbit());
            idle_events();
        end
        // the camera writes its reply, or opens an exchange of its own
        emit(OP_MATCH, 1'b0, rlen(), rbit(), rbit());
        transfer_ticks();
        advance_clock();
        emit(OP_STOP, rbit(), rlen(), ($urandom_range(0, 3) != 0), rbit());
        idle_events();
        // the camera reads our response
        emit(OP_MATCH, 1'b1, rlen(), rbit(), rbit());
        transfer_ticks();
        advance_clock();
        emit(OP_STOP, rbit(), rlen(), rbit(), rbit());
    endtask

    // ---------------------------------------------------------------------
    // Directed table helpers
    // ---------------------------------------------------------------------
    function automatic t_result result_word(input t_phase ph, input logic intr,
                                            input logic snd, input logic [LEN_W-1:0] len,
                                            input logic rcv, input logic fail,
                                            input logic refused);
        t_result r;
        r.phase           = ph;
        r.intr_drive      = intr;
        r.start_send      = snd;
        r.send_len        = len;
        r.start_receive   = rcv;
        r.txn_failed      = fail;
        r.request_refused = refused;
        return r;
    endfunction

    function automatic t_row script_row(input logic [OP_W-1:0] op, input logic [31:0] now,
                                        input logic as_tx, input logic [LEN_W-1:0] len,
                                        input logic rsp, input logic follow,
                                        input logic typed, input t_result want);
        t_row r;
        r.ev.op              = op;
        r.ev.now_us          = now;
        r.ev.cam_reads       = as_tx;
        r.ev.cmd_len         = len;
        r.ev.rx_has_response = rsp;
        r.ev.follow_on_cmd   = follow;
        r.typed              = typed;
        r.want               = want;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Result sink: random stalls, mostly short
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0)
                sink_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                         : $urandom_range(1, 3);
        end
    end

    // compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata);
            words_seen++;
            sends_seen    += got.start_send;
            receives_seen += got.start_receive;
            failures_seen += got.txn_failed;
            refusals_seen += got.request_refused;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result word %0d arrived with nothing expected: %h",
                             words_seen, m_axis_tdata);
            end else begin
                want = expected_words.pop_front();
                if (got.phase !== want.phase || got.intr_drive !== want.intr_drive ||
                    got.start_send !== want.start_send || got.send_len !== want.send_len ||
                    got.start_receive !== want.start_receive ||
                    got.txn_failed !== want.txn_failed ||
                    got.request_refused !== want.request_refused) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"result word %0d (expected/actual): phase %0d/%0d ",
                                  "intr %b/%b send %b/%b len %0d/%0d rx %b/%b ",
                                  "fail %b/%b refused %b/%b"}, words_seen,
                                 want.phase, got.phase, want.intr_drive, got.intr_drive,
                                 want.start_send, got.start_send, want.send_len,
                                 got.send_len, want.start_receive, got.start_receive,
                                 want.txn_failed, got.txn_failed,
                                 want.request_refused, got.request_refused);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[camera_bus_transaction_sequencer] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin : stimulus
        t_row        script[$];
        int unsigned goal;
        t_result     zero_idle;

        // reset values of the prediction
        settle_us     = 16'd500;
        ignore_ticks  = 16'd666;
        pulse_ticks   = 8'd0;
        timeout_ticks = 16'd100;
        seq_phase     = PH_IDLE;
        xfer_on       = 1'b0;
        xfer_tx       = 1'b0;
        line_up       = 1'b0;
        line_pending  = 1'b0;
        pulsing       = 1'b0;
        line_ticks    = '0;
        xfer_ticks    = '0;
        stop_stamp    = '0;
        queued_len    = '0;
        events_sent   = 0;
        words_seen    = 0;
        mismatches    = 0;
        sends_seen    = 0;
        receives_seen = 0;
        failures_seen = 0;
        refusals_seen = 0;
        settings_used = 1;
        cycle_count   = 0;
        zero_idle     = result_word(PH_IDLE, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);

        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed walk at the reset settings (settle 500 us, timeout 100 ticks)
        // tick and spare codes right after reset: nothing moves
        script.push_back(script_row(OP_TICK, 32'd0, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, zero_idle));
        script.push_back(script_row(OP_SPARE_LO, 32'd10, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1,
                                    zero_idle));
        script.push_back(script_row(OP_SPARE_HI, 32'd20, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1,
                                    zero_idle));
        // stop with no transfer: only the stop time changes
        script.push_back(script_row(OP_STOP, 32'd1000, 1'b0, 8'd0, 1'b1, 1'b1, 1'b1,
                                    zero_idle));
        // request too soon after the stop: assertion held back
        script.push_back(script_row(OP_REQ, 32'd1200, 1'b0, 8'hFF, 1'b0, 1'b0, 1'b1,
                         result_word(PH_AWAIT_CMD_READ, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0,
                                     1'b0)));
        // second request while busy: refused
        script.push_back(script_row(OP_REQ, 32'd1300, 1'b1, 8'd3, 1'b1, 1'b1, 1'b1,
                         result_word(PH_AWAIT_CMD_READ, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0,
                                     1'b1)));
        // poll exactly at the settle time: still held; one microsecond later it fires
        script.push_back(script_row(OP_POLL, 32'd1500, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, '0));
        script.push_back(script_row(OP_POLL, 32'd1501, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1,
                         result_word(PH_AWAIT_CMD_READ, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0,
                                     1'b0)));
        // camera reads the command
        script.push_back(script_row(OP_MATCH, 32'd1600, 1'b1, 8'd0, 1'b0, 1'b0, 1'b1,
                         result_word(PH_SENDING_CMD, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b0,
                                     1'b0)));
        script.push_back(script_row(OP_STOP, 32'd2000, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, '0));
        // camera writes its reply, with a response to send back
        script.push_back(script_row(OP_MATCH, 32'd2100, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, '0));
        script.push_back(script_row(OP_STOP, 32'd2200, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0, '0));
        script.push_back(script_row(OP_POLL, 32'd2701, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, '0));
        script.push_back(script_row(OP_MATCH, 32'd2800, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0, '0));
        // response read done, follow-on command of 128 bytes
        script.push_back(script_row(OP_STOP, 32'd3000, 1'b0, 8'h80, 1'b0, 1'b1, 1'b0, '0));
        // camera write preempts the waiting command
        script.push_back(script_row(OP_MATCH, 32'd3100, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1,
                         result_word(PH_RECEIVING, 1'b0, 1'b0, 8'd0, 1'b1, 1'b1, 1'b0)));
        script.push_back(script_row(OP_STOP, 32'd3200, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, '0));
        // read while idle, then its stop: both land back in idle
        script.push_back(script_row(OP_MATCH, 32'd3300, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0, '0));
        script.push_back(script_row(OP_STOP, 32'd3400, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0, '0));
        // time stamps across the wrap of the microsecond counter
        script.push_back(script_row(OP_STOP, 32'hFFFF_FF00, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b0,
                                    '0));
        script.push_back(script_row(OP_REQ, 32'h0000_0100, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0, '0));
        script.push_back(script_row(OP_TICK, 32'h0000_0200, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0,
                                    '0));
        script.push_back(script_row(OP_MATCH, 32'h0000_0300, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0,
                                    '0));
        // camera write in the middle of our send: wrong phase
        script.push_back(script_row(OP_MATCH, 32'h0000_0400, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0,
                                    '0));
        script.push_back(script_row(OP_STOP, 32'h0000_0500, 1'b0, 8'd0, 1'b1, 1'b1, 1'b0,
                                    '0));
        foreach (script[k])
            push_event(script[k].ev, script[k].typed, script[k].want);
        directed_count = events_sent;

        // random exchanges, one register setting per phase
        clock_us = 32'd5000;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       load_settings(16'd0, 16'd1, 8'd0, 16'd0);
                1:       load_settings(16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
                2:       load_settings(16'd500, 16'd2, 8'd1, 16'd3);
                default: load_settings($urandom_range(0, 800), $urandom_range(1, 6),
                                       $urandom_range(0, 4), $urandom_range(0, 10));
            endcase
            calm <= (p == 3) || (p == 7);
            goal = events_sent + ITEMS_PER_PHASE;
            while (events_sent < goal - ITEMS_PER_PHASE / 2)
                run_exchange();
            // pause the sender until the block has emptied out
            drain_results();
            while (events_sent < goal)
                run_exchange();
        end

        drain_results();
        repeat (FLUSH_CYCLES) @(posedge i_clk);
        mismatches += expected_words.size();

        $display("summary: %0d event words (%0d directed) over %0d register settings, %0d checked",
                 events_sent, directed_count, settings_used, words_seen);
        $display("summary: %0d sends, %0d receives, %0d failures, %0d refusals, %0d mismatches",
                 sends_seen, receives_seen, failures_seen, refusals_seen, mismatches);
        if (mismatches == 0)
            $display("[camera_bus_transaction_sequencer] OK");
        else
            $display("[camera_bus_transaction_sequencer] ERROR");
        $finish;
    end

endmodule

### sim.f
sv/cbts_pkg.sv
sv/cbts_core.sv
sv/cbts_out.sv
sv/camera_bus_transaction_sequencer.sv
dv/camera_bus_transaction_sequencer_test.sv
